[design/dht_pkg.sv]
// Shared types, constants and codes for the double hash table engine.
package dht_pkg;

    localparam int SLOTS    = 64;
    localparam int SLOT_W   = 6;
    localparam int SIZE_W   = 7;
    localparam int PRIME_W  = 6;
    localparam int KEY_W    = 31;
    localparam int CNT_W    = 5;

    localparam logic [1:0] MARK_EMPTY = 2'd0;
    localparam logic [1:0] MARK_USED  = 2'd1;
    localparam logic [1:0] MARK_GONE  = 2'd2;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_DELETED  = 2'd1;
    localparam logic [1:0] ST_ABSENT   = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_DELETE = 1'b1;

    localparam logic REG_TABLE_SIZE = 1'b0;
    localparam logic REG_STEP_PRIME = 1'b1;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;      // capture key, mode and live sizes
        logic div_step;  // one restoring division step on both remainders
        logic fix_step;  // form the raw probe step and the home slot
        logic reduce;    // subtract the table size once from the step
        logic rd;        // issue a read of the current probe slot
        logic judge;     // evaluate the read data
        logic advance;   // move to the next probe slot
    } t_dht_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic div_done;
        logic step_ok;   // step is below the table size
        logic hit;       // probe decides the operation
        logic last;      // this was the final allowed probe
    } t_dht_sts;

endpackage

[design/dht_datapath.sv]
// Datapath: remainder unit, probe arithmetic and the slot memories.
module dht_datapath
    import dht_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dht_cmd             i_cmd,
    output t_dht_sts             o_sts,
    input  logic                 i_mode,
    input  logic [KEY_W-1:0]     i_key,
    input  logic [SIZE_W-1:0]    i_size,
    input  logic [PRIME_W-1:0]   i_prime,
    output logic [1:0]           o_status,
    output logic [SLOT_W-1:0]    o_slot,
    output logic [SIZE_W-1:0]    o_probes
);

    // Key store without reset; marks are flops cleared by reset.
    logic [KEY_W-1:0]  r_keys [SLOTS];
    logic [1:0]        r_marks [SLOTS];

    logic              r_mode;
    logic [KEY_W-1:0]  r_key;
    logic [SIZE_W-1:0] r_n;
    logic [PRIME_W-1:0] r_pr;
    logic [KEY_W-1:0]  r_quot_n, r_quot_p;
    logic [SIZE_W-1:0] r_rem_n;
    logic [PRIME_W:0]  r_rem_p;
    logic [CNT_W-1:0]  r_bit;
    logic [SLOT_W-1:0] r_pos;
    logic [SIZE_W-1:0] r_step;
    logic [SIZE_W-1:0] r_k;
    logic [KEY_W-1:0]  r_rd_key;
    logic [1:0]        r_rd_mark;

    logic [SIZE_W:0]   w_tn;
    logic [PRIME_W+1:0] w_tp;
    logic [SIZE_W:0]   w_sum;
    logic              w_found, w_stop;

    // Shifted remainders for this division step.
    assign w_tn = {r_rem_n, r_quot_n[KEY_W-1]};
    assign w_tp = {r_rem_p, r_quot_p[KEY_W-1]};
    assign w_sum = {2'b0, r_pos} + {1'b0, r_step};

    // Probe decision on the registered read data.
    assign w_found = (r_rd_mark == MARK_USED) && (r_rd_key == r_key);
    always_comb begin
        if (r_mode == MODE_INSERT) begin
            w_stop = (r_rd_mark != MARK_USED);
        end else begin
            w_stop = w_found || (r_rd_mark == MARK_EMPTY);
        end
    end
    assign o_sts.hit = w_stop;
    assign o_sts.last = (r_k + SIZE_W'(1)) == r_n;
    assign o_sts.div_done = (r_bit == '0);
    assign o_sts.step_ok = (r_step < r_n);

    // Operand capture and the bit-serial remainder unit.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode   <= i_mode;
            r_key    <= i_key;
            r_n      <= (i_size == '0) ? SIZE_W'(1)
                      : (i_size > SIZE_W'(SLOTS)) ? SIZE_W'(SLOTS) : i_size;
            r_pr     <= (i_prime == '0) ? PRIME_W'(1) : i_prime;
            r_quot_n <= i_key;
            r_quot_p <= i_key;
            r_rem_n  <= '0;
            r_rem_p  <= '0;
            r_bit    <= CNT_W'(KEY_W);
            r_k      <= '0;
        end else if (i_cmd.div_step) begin
            r_quot_n <= {r_quot_n[KEY_W-2:0], 1'b0};
            r_quot_p <= {r_quot_p[KEY_W-2:0], 1'b0};
            r_rem_n  <= (w_tn >= {1'b0, r_n}) ? SIZE_W'(w_tn - {1'b0, r_n})
                                               : w_tn[SIZE_W-1:0];
            r_rem_p  <= (w_tp >= {2'b0, r_pr}) ? (PRIME_W+1)'(w_tp - {2'b0, r_pr})
                                                : w_tp[PRIME_W:0];
            r_bit    <= r_bit - CNT_W'(1);
        end else if (i_cmd.fix_step) begin
            // Step is pr - rem in 1..63; reduce once per cycle until below n.
            r_pos  <= r_rem_n[SLOT_W-1:0];
            r_step <= SIZE_W'({1'b0, r_pr} - r_rem_p[PRIME_W-1:0]);
        end else if (i_cmd.advance) begin
            r_pos <= (w_sum >= {1'b0, r_n}) ? SLOT_W'(w_sum - {1'b0, r_n})
                                            : w_sum[SLOT_W-1:0];
            r_k   <= r_k + SIZE_W'(1);
        end else if (i_cmd.reduce) begin
            r_step <= r_step - r_n;
        end
    end
    assign o_probes = r_k + SIZE_W'(1);

    // Registered memory read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_key  <= r_keys[r_pos];
            r_rd_mark <= r_marks[r_pos];
        end
    end

    // Memory writes on a decision.
    always_ff @(posedge i_clk) begin
        if (i_cmd.judge && w_stop && (r_mode == MODE_INSERT)) begin
            r_keys[r_pos] <= r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) r_marks[i] <= MARK_EMPTY;
        end else if (i_cmd.judge && w_stop) begin
            if (r_mode == MODE_INSERT) begin
                r_marks[r_pos] <= MARK_USED;
            end else if (w_found) begin
                r_marks[r_pos] <= MARK_GONE;
            end
        end
    end

    // Result fields.
    always_comb begin
        if (w_stop && r_mode == MODE_INSERT) begin
            o_status = ST_INSERTED;
        end else if (w_stop && w_found) begin
            o_status = ST_DELETED;
        end else if (r_mode == MODE_INSERT) begin
            o_status = ST_FULL;
        end else begin
            o_status = ST_ABSENT;
        end
        o_slot = (o_status == ST_INSERTED || o_status == ST_DELETED) ? r_pos : '0;
    end

endmodule

[design/dht_ctrl.sv]
// Controller state machine sequencing division, step reduction and probes.
module dht_ctrl
    import dht_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    output logic     o_busy,
    output logic     o_done,
    output t_dht_cmd o_cmd,
    input  t_dht_sts i_sts
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIV   = 6'b000010,
        S_FIX   = 6'b000100,
        S_READ  = 6'b001000,
        S_JUDGE = 6'b010000,
        S_WAIT  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_done  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.fix_step = 1'b1;
                    n_state = S_WAIT;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_WAIT: begin
                // Step reduction: subtract the table size until the step is below it.
                if (i_sts.step_ok) begin
                    n_state = S_FIX;
                end else begin
                    o_cmd.reduce = 1'b1;
                end
            end
            S_FIX: begin
                n_state = S_READ;
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state = S_JUDGE;
            end
            S_JUDGE: begin
                o_cmd.judge = 1'b1;
                if (i_sts.hit || i_sts.last) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state = S_READ;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
    assign o_busy = (r_state != S_IDLE);

endmodule

[design/double_hash_table_engine.sv]
// Sequence: a serial division, then step setup (step reduced by repeated
//   subtraction, up to 63), then a read state and a judge state per probe slot examined.
// Operations run one at a time, as set by the serial remainder unit and the
//   single read port of the slot memory.
// A waiting result holds off the next operation until it is taken.
// Reset (synchronous, active low) clears all slot marks at once, table_size to 64
//   and step_prime to 7; stored keys are not cleared.
module double_hash_table_engine
    import dht_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [30:0] key, [31] zero
    input  logic        s_axis_tuser,   // [0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [1:0] status, [7:2] slot, [14:8] probes, [15] zero
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [6:0]  i_cfg_data
);

    t_dht_cmd w_cmd;
    t_dht_sts w_sts;
    logic w_busy, w_done, w_start;
    logic [1:0] w_status;
    logic [SLOT_W-1:0] w_slot;
    logic [SIZE_W-1:0] w_probes;
    logic [SIZE_W-1:0] r_size;
    logic [PRIME_W-1:0] r_prime;
    logic r_ovalid;
    logic [15:0] r_odata;

    assign s_axis_tready = !w_busy && (!r_ovalid || m_axis_tready);
    assign w_start = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size  <= SIZE_W'(64);
            r_prime <= PRIME_W'(7);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_TABLE_SIZE) r_size <= i_cfg_data;
            else r_prime <= i_cfg_data[PRIME_W-1:0];
        end
    end

    dht_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .o_busy(w_busy), .o_done(w_done), .o_cmd(w_cmd), .i_sts(w_sts)
    );

    dht_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_sts(w_sts),
        .i_mode(s_axis_tuser), .i_key(s_axis_tdata[KEY_W-1:0]),
        .i_size(r_size), .i_prime(r_prime),
        .o_status(w_status), .o_slot(w_slot), .o_probes(w_probes)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_done) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_done) r_odata <= {1'b0, w_probes, w_slot, w_status};
    end
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    // No new operation starts while a previous one is in progress.
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !w_start) else $error("start while busy");
    // A result is reported only for an operation that was started.
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> w_busy) else $error("done while idle");
    // Probe count never exceeds the table.
    a_probes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (w_probes <= SIZE_W'(SLOTS))) else $error("probe overrun");

endmodule
